FILE: hdl/twh_pkg.sv
// ============================================================================
// twh_pkg
// Shared types and constants of the trapezoid window hydrophobicity block.
// ============================================================================
package twh_pkg;

    localparam int HYDRO_W    = 16;
    localparam int LETTER_W   = 5;
    localparam int TABLE_SIZE = 26;
    localparam int CORE_W     = 6;
    localparam int WEDGE_W    = 5;
    localparam int CFG_DATA_W = 6;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CORE_W-1:0]    CORE_RESET  = 6'd11;
    localparam logic [WEDGE_W-1:0]   WEDGE_RESET = 5'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_CORE_LENGTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WEDGE_LENGTH = 1'b1;

    localparam logic OP_TABLE_WRITE = 1'b0;
    localparam logic OP_RESIDUE     = 1'b1;

    typedef struct packed {
        logic                      opcode;
        logic [LETTER_W-1:0]       letter;
        logic signed [HYDRO_W-1:0] hydro_value;
        logic                      start_of_sequence;
    } t_item;

    typedef struct packed {
        logic signed [HYDRO_W-1:0] profile_value;
        logic [HYDRO_W-1:0]        window_start;
    } t_result;

endpackage

FILE: hdl/twh_stream_if.sv
// ============================================================================
// twh_stream_if
// Valid/ready stream channel carrying one payload item per transfer.
// ============================================================================
interface twh_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/twh_cell.sv
// ============================================================================
// twh_cell
// One window cell: holds a table value and takes its neighbour's on a shift.
// ============================================================================
module twh_cell
    import twh_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [HYDRO_W-1:0] i_d,
    output logic signed [HYDRO_W-1:0] o_q
);

    logic signed [HYDRO_W-1:0] r_value;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_value <= i_d;
        end
    end

    assign o_q = r_value;

endmodule

FILE: hdl/twh_chain.sv
// ============================================================================
// twh_chain
// Row of window cells, newest value in cell 0. It either shifts a new value
// in or rotates so that every stored value passes the tap at the last cell.
// ============================================================================
module twh_chain
    import twh_pkg::*;
#(
    parameter int MAX_WINDOW = 64
) (
    input  logic                      i_clk,
    input  logic                      i_shift,
    input  logic                      i_wrap,
    input  logic signed [HYDRO_W-1:0] i_value,
    output logic signed [HYDRO_W-1:0] o_tap
);

    logic signed [HYDRO_W-1:0] w_q [MAX_WINDOW];
    logic signed [HYDRO_W-1:0] w_head;

    assign w_head = i_wrap ? w_q[MAX_WINDOW-1] : i_value;

    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        if (g == 0) begin : g_first
            twh_cell u_cell (
                .i_clk (i_clk),
                .i_en  (i_shift),
                .i_d   (w_head),
                .o_q   (w_q[g])
            );
        end else begin : g_rest
            twh_cell u_cell (
                .i_clk (i_clk),
                .i_en  (i_shift),
                .i_d   (w_q[g-1]),
                .o_q   (w_q[g])
            );
        end
    end

    assign o_tap = w_q[MAX_WINDOW-1];

endmodule

FILE: hdl/twh_divider.sv
// ============================================================================
// twh_divider
// Signed divide by a positive divisor, truncating toward zero. One quotient
// bit per cycle by restoring subtraction of the shifted divisor.
// ============================================================================
module twh_divider
    import twh_pkg::*;
#(
    parameter int DIVIDEND_W = 29,
    parameter int DIVISOR_W  = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]         i_divisor,
    output logic                         o_done,
    output logic signed [HYDRO_W-1:0]    o_quotient
);

    localparam int RW = DIVISOR_W + HYDRO_W + 1;
    localparam int CW = $clog2(HYDRO_W);

    logic                  r_busy;
    logic                  r_done;
    logic [CW-1:0]         r_cnt;
    logic [RW-1:0]         r_rem;
    logic [RW-1:0]         r_dsh;
    logic [HYDRO_W-1:0]    r_quot;
    logic                  r_neg;

    logic [DIVIDEND_W-1:0] w_mag;
    logic                  w_ge;

    assign w_mag = i_dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-i_dividend)
                                            : DIVIDEND_W'(i_dividend);
    assign w_ge  = (r_rem >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= RW'(w_mag);
            r_dsh  <= RW'({i_divisor, {(HYDRO_W-1){1'b0}}});
            r_quot <= '0;
            r_neg  <= i_dividend[DIVIDEND_W-1];
            r_cnt  <= CW'(HYDRO_W - 1);
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_quot <= {r_quot[HYDRO_W-2:0], w_ge};
            r_dsh  <= r_dsh >> 1;
            r_cnt  <= r_cnt - 1'b1;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? -$signed(r_quot) : $signed(r_quot);

endmodule

FILE: hdl/trapezoid_window_hydrophobicity.sv
// ============================================================================
// trapezoid_window_hydrophobicity
// Trapezoid-weighted sliding-window hydrophobicity profile of a residue
// stream, with a loadable 26-entry letter table.
//
//   Channel   Direction  Payload                               Transfer when
//   i_item    in         opcode, letter, hydro_value, start    valid && ready
//   o_result  out        profile_value, window_start           valid && ready
//   i_cfg_*   in         core_length (0), wedge_length (1)     i_cfg_we
//
// A table write is taken in S_IDLE; a residue that gives no result passes
// S_CHK and goes back to S_IDLE. For a residue with a result the cell chain
// rotates once past its tap, one product a cycle, the sum is completed, and
// then the divider makes one quotient bit per cycle. One item is in work at a time.
// Reset is synchronous; it clears the table, the count and the control
// registers. The window cells are not cleared, and cells outside the window
// are kept out of the sum.
// A result waits in the output register while the next item is taken; a
// further result stalls until that register is free.
// ============================================================================
module trapezoid_window_hydrophobicity
    import twh_pkg::*;
#(
    parameter int MAX_WINDOW = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    twh_stream_if.sink            i_item,
    twh_stream_if.source          o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int LW    = $clog2(MAX_WINDOW + 1);
    localparam int WW    = (LW > CORE_W) ? LW : CORE_W;
    localparam int JW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int MAXS  = MAX_WINDOW * (MAX_WINDOW / 2 + 1);
    localparam int DW    = $clog2(MAXS + 1);
    localparam int SW    = HYDRO_W + 1 + $clog2(MAXS);
    localparam int PW    = HYDRO_W + LW + 1;
    localparam int CNTW  = $clog2(65536 + MAX_WINDOW);
    localparam logic [CNTW-1:0] COUNT_LIMIT = CNTW'(65535 + MAX_WINDOW);
    localparam logic [CNTW-1:0] POS_LIMIT   = CNTW'(65535);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_CHK  = 7'b0000010,
        S_SCAN = 7'b0000100,
        S_SUM  = 7'b0001000,
        S_LOAD = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state                    r_state;
    t_state                    n_state;

    logic [CORE_W-1:0]         r_core_length;
    logic [WEDGE_W-1:0]        r_wedge_length;
    logic signed [HYDRO_W-1:0] r_table [TABLE_SIZE];
    logic [CNTW-1:0]           r_count;

    logic [LW-1:0]             r_n;
    logic [LW-1:0]             r_q;
    logic [LW-1:0]             r_len;
    logic [DW-1:0]             r_div;
    logic [HYDRO_W-1:0]        r_pos;
    logic [JW-1:0]             r_j;
    logic signed [PW-1:0]      r_prod;
    logic signed [SW-1:0]      r_acc;

    logic                      r_out_valid;
    t_result                   r_result;

    logic                      w_in_fire;
    logic                      w_residue;
    t_item                     w_item;
    logic signed [HYDRO_W-1:0] w_lookup;
    logic [WW-1:0]             w_n_raw;
    logic [WW-1:0]             w_n;
    logic [WW-1:0]             w_q_raw;
    logic [WW-1:0]             w_q_max;
    logic [WW-1:0]             w_q;
    logic [WW-1:0]             w_len;
    logic [CNTW-1:0]           w_count_base;
    logic [CNTW-1:0]           w_pos_full;
    logic [2*LW+1:0]           w_div_full;
    logic [LW-1:0]             w_jl;
    logic [LW-1:0]             w_wa;
    logic [LW-1:0]             w_wb;
    logic [LW-1:0]             w_wc;
    logic [LW-1:0]             w_wab;
    logic [LW-1:0]             w_weight;
    logic signed [HYDRO_W-1:0] w_tap;
    logic signed [HYDRO_W-1:0] w_term;
    logic                      w_out_free;
    logic                      w_div_done;
    logic signed [HYDRO_W-1:0] w_quotient;

    assign w_item    = i_item.data;
    assign w_in_fire = i_item.valid && i_item.ready;
    assign w_residue = w_in_fire && (w_item.opcode == OP_RESIDUE);

    assign i_item.ready = (r_state == S_IDLE);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_core_length  <= CORE_RESET;
            r_wedge_length <= WEDGE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CORE_LENGTH: begin
                    r_core_length <= i_cfg_data[CORE_W-1:0];
                end
                CFG_WEDGE_LENGTH: begin
                    r_wedge_length <= i_cfg_data[WEDGE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Letter table.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_SIZE; i++) begin
                r_table[i] <= '0;
            end
        end else if (w_in_fire && (w_item.opcode == OP_TABLE_WRITE)
                     && (w_item.letter < LETTER_W'(TABLE_SIZE))) begin
            r_table[w_item.letter] <= w_item.hydro_value;
        end
    end

    assign w_lookup = (w_item.letter < LETTER_W'(TABLE_SIZE)) ? r_table[w_item.letter]
                                                              : '0;

    // Effective window geometry from the current register values.
    assign w_n_raw = WW'(r_core_length);
    assign w_n     = (w_n_raw == '0) ? WW'(1) :
                     (w_n_raw > WW'(MAX_WINDOW)) ? WW'(MAX_WINDOW) : w_n_raw;
    assign w_q_raw = WW'(r_wedge_length);
    assign w_q_max = (WW'(MAX_WINDOW) - w_n) >> 1;
    assign w_q     = (w_q_raw > w_q_max) ? w_q_max : w_q_raw;
    assign w_len   = (w_q << 1) + w_n;

    assign w_count_base = w_item.start_of_sequence ? '0 : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_residue) begin
            if (w_count_base < COUNT_LIMIT) begin
                r_count <= w_count_base + 1'b1;
            end else begin
                r_count <= w_count_base;
            end
        end
    end

    // Cell chain.
    twh_chain #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_chain (
        .i_clk   (i_clk),
        .i_shift (w_residue || (r_state == S_SCAN)),
        .i_wrap  (r_state == S_SCAN),
        .i_value (w_lookup),
        .o_tap   (w_tap)
    );

    // Weight of the value at the tap: min(j+1, q+1, len-j) inside the window.
    assign w_jl     = LW'(r_j);
    assign w_wa     = w_jl + 1'b1;
    assign w_wb     = r_q + 1'b1;
    assign w_wc     = r_len - w_jl;
    assign w_wab    = (w_wa < w_wb) ? w_wa : w_wb;
    assign w_weight = (w_jl >= r_len) ? '0 : ((w_wab < w_wc) ? w_wab : w_wc);
    assign w_term   = (w_jl >= r_len) ? '0 : w_tap;

    assign w_div_full = ({1'b0, r_q} + 1'b1) * ({1'b0, r_n} + {1'b0, r_q});
    assign w_pos_full = r_count - CNTW'(r_len);

    always_ff @(posedge i_clk) begin
        if (w_residue) begin
            r_n   <= w_n[LW-1:0];
            r_q   <= w_q[LW-1:0];
            r_len <= w_len[LW-1:0];
        end
        if (r_state == S_CHK) begin
            r_div  <= w_div_full[DW-1:0];
            r_pos  <= (w_pos_full > POS_LIMIT) ? HYDRO_W'(65535)
                                               : w_pos_full[HYDRO_W-1:0];
            r_j    <= JW'(MAX_WINDOW - 1);
            r_prod <= '0;
            r_acc  <= '0;
        end else if (r_state == S_SCAN) begin
            r_j    <= r_j - 1'b1;
            r_prod <= w_term * $signed({1'b0, w_weight});
            r_acc  <= r_acc + SW'(r_prod);
        end else if (r_state == S_SUM) begin
            r_acc  <= r_acc + SW'(r_prod);
        end
    end

    twh_divider #(
        .DIVIDEND_W (SW),
        .DIVISOR_W  (DW)
    ) u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_LOAD),
        .i_dividend (r_acc),
        .i_divisor  (r_div),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    assign w_out_free = !r_out_valid || o_result.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_residue) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (r_count < CNTW'(r_len)) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_j == '0) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_OUT) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && w_out_free) begin
            r_result.profile_value <= w_quotient;
            r_result.window_start  <= r_pos;
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_result;

endmodule

FILE: verif/tb_top.sv
// ============================================================================
// tb_top
// Self-checking bench for the trapezoid window hydrophobicity block. Items
// are fed from a queue by a clocked driver, and every accepted item goes
// through a cycle-free predictor of the table, the window and the residue
// count. Each result transfer is compared with the oldest prediction. The run
// starts with a short directed sequence and then walks through several window
// settings with random sequences, random gaps on both sides and one long
// receiver hold-off.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import twh_pkg::*;

    localparam int WINDOW_DEPTH  = 64;
    localparam int unsigned COUNT_CAP = 65535 + WINDOW_DEPTH;
    localparam int IDLE_MAX      = 17;
    localparam int SETTLE_CYCLES = WINDOW_DEPTH + 40;
    localparam int PHASES        = 9;
    localparam int PHASE_ITEMS   = 60;
    localparam int HOLD_AT_ITEM  = 140;
    localparam int HOLD_CYCLES   = 400;
    localparam int CORE_PLAN  [6] = '{11, 1, 63, 0, 32, 2};
    localparam int WEDGE_PLAN [6] = '{5, 0, 0, 31, 16, 1};

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    twh_stream_if #(.T(t_item))   item_if ();
    twh_stream_if #(.T(t_result)) result_if ();

    trapezoid_window_hydrophobicity #(
        .MAX_WINDOW(WINDOW_DEPTH)
    ) u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (item_if),
        .o_result  (result_if),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    t_item                     pending_items [$];
    t_result                   expected_profiles [$];
    logic [CORE_W-1:0]         core_len_cfg;
    logic [WEDGE_W-1:0]        wedge_len_cfg;
    logic signed [HYDRO_W-1:0] hydro_lut [TABLE_SIZE];
    logic signed [HYDRO_W-1:0] window_vals [WINDOW_DEPTH];
    int unsigned               seq_count;
    int unsigned               items_taken;
    int                        fail_count;
    int                        send_gap;
    int                        recv_stall;
    int                        send_idle_max;
    int                        recv_idle_max;
    bit                        item_moved;
    bit                        result_moved;
    bit                        hold_off;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic void window_shape(output int n, output int q);
        n = core_len_cfg;
        if (n < 1) n = 1;
        if (n > WINDOW_DEPTH) n = WINDOW_DEPTH;
        q = wedge_len_cfg;
        if (q > (WINDOW_DEPTH - n) / 2) q = (WINDOW_DEPTH - n) / 2;
    endfunction

    function automatic bit predict_profile(input t_item it, output t_result res);
        int          n;
        int          q;
        int          len;
        int          w;
        longint      acc;
        longint      quot;
        int unsigned pos;
        res = '0;
        if (it.opcode == OP_TABLE_WRITE) begin
            if (it.letter < TABLE_SIZE) hydro_lut[it.letter] = it.hydro_value;
            return 1'b0;
        end
        if (it.start_of_sequence) seq_count = 0;
        for (int i = WINDOW_DEPTH - 1; i > 0; i--) window_vals[i] = window_vals[i-1];
        window_vals[0] = (it.letter < TABLE_SIZE) ? hydro_lut[it.letter] : '0;
        if (seq_count < COUNT_CAP) seq_count++;
        window_shape(n, q);
        len = 2 * q + n;
        if (seq_count < len) return 1'b0;
        acc = 0;
        for (int k = 1; k <= len; k++) begin
            if (k <= q) w = k;
            else if (k <= q + n) w = q + 1;
            else w = len + 1 - k;
            acc += longint'(window_vals[len-k]) * w;
        end
        quot = acc / (longint'(q + 1) * (n + q));
        pos = seq_count - len;
        if (pos > 65535) pos = 65535;
        res.profile_value = 16'(quot);
        res.window_start  = 16'(pos);
        return 1'b1;
    endfunction

    function automatic t_item make_item(logic op, logic [LETTER_W-1:0] letter,
                                        logic [HYDRO_W-1:0] value, logic sos);
        t_item it;
        it.opcode            = op;
        it.letter            = letter;
        it.hydro_value       = value;
        it.start_of_sequence = sos;
        return it;
    endfunction

    // Sequences of random length around the window size, with a sprinkling of
    // table writes, unknown letters and early restarts.
    task automatic queue_sequences(input int count);
        int    n;
        int    q;
        int    produced;
        int    seq_len;
        t_item it;
        window_shape(n, q);
        produced = 0;
        while (produced < count) begin
            seq_len = $urandom_range(1, 2 * (2 * q + n) + 8);
            for (int j = 0; j < seq_len && produced < count; j++) begin
                it = make_item(OP_RESIDUE, 5'($urandom_range(0, TABLE_SIZE - 1)),
                               16'($urandom), 1'b0);
                if ($urandom_range(0, 99) < 6) it.letter = 5'($urandom_range(TABLE_SIZE, 31));
                if (j == 0) it.start_of_sequence = (produced != 0) || $urandom_range(0, 1);
                else if ($urandom_range(0, 99) < 3) it.start_of_sequence = 1'b1;
                if ($urandom_range(0, 99) < 8) begin
                    it.opcode            = OP_TABLE_WRITE;
                    it.letter            = 5'($urandom);
                    it.start_of_sequence = 1'($urandom);
                end
                pending_items.push_back(it);
                produced++;
            end
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == CFG_CORE_LENGTH) core_len_cfg = value[CORE_W-1:0];
        else wedge_len_cfg = value[WEDGE_W-1:0];
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || item_if.valid || expected_profiles.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : monitor
        t_result want;
        t_result got;
        if (i_rst_n) begin
            if (result_if.valid && result_if.ready) begin
                got          = result_if.data;
                result_moved = 1'b1;
                if (expected_profiles.size() == 0) begin
                    $error("unexpected result transfer: profile_value %0d window_start %0d",
                           got.profile_value, got.window_start);
                    fail_count++;
                end else begin
                    want = expected_profiles.pop_front();
                    if (got.profile_value !== want.profile_value) begin
                        $error("profile_value: expected %0d, got %0d",
                               want.profile_value, got.profile_value);
                        fail_count++;
                    end
                    if (got.window_start !== want.window_start) begin
                        $error("window_start: expected %0d, got %0d",
                               want.window_start, got.window_start);
                        fail_count++;
                    end
                end
            end
            if (item_if.valid && item_if.ready) begin
                item_moved = 1'b1;
                items_taken++;
                if (predict_profile(item_if.data, want)) expected_profiles.push_back(want);
            end
        end
    end

    always @(negedge i_clk) begin : item_driver
        bit offer;
        offer = item_if.valid;
        if (item_moved) begin
            offer      = 1'b0;
            item_moved = 1'b0;
        end
        if (!offer) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (pending_items.size() > 0) begin
                item_if.data <= pending_items.pop_front();
                offer         = 1'b1;
                send_gap      = $urandom_range(0, send_idle_max);
            end
        end
        item_if.valid <= offer;
    end

    always @(negedge i_clk) begin : result_sink
        if (result_moved) begin
            result_moved = 1'b0;
            recv_stall   = $urandom_range(0, recv_idle_max);
        end
        if (hold_off) begin
            result_if.ready <= 1'b0;
        end else if (recv_stall > 0) begin
            recv_stall--;
            result_if.ready <= 1'b0;
        end else begin
            result_if.ready <= 1'b1;
        end
    end

    // A long refusal while the sender keeps offering, so that the block fills
    // up and has to hold off further transfers on its input.
    initial begin : long_hold
        wait (items_taken >= HOLD_AT_ITEM);
        @(posedge i_clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off = 1'b0;
    end

    initial begin : watchdog
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [LETTER_W-1:0] pattern [6];
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_data      = '0;
        item_if.valid   = 1'b0;
        item_if.data    = '0;
        result_if.ready = 1'b0;
        core_len_cfg    = CORE_RESET;
        wedge_len_cfg   = WEDGE_RESET;
        seq_count       = 0;
        foreach (hydro_lut[i]) hydro_lut[i] = '0;
        foreach (window_vals[i]) window_vals[i] = '0;
        send_idle_max   = IDLE_MAX;
        recv_idle_max   = IDLE_MAX;
        pattern         = '{5'd0, 5'd25, 5'd5, 5'd31, 5'd26, 5'd2};

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed sequence at the reset window: extreme table values, an
        // ignored write to an unknown letter, and residues with unknown and
        // never-written letters.
        pending_items.push_back(make_item(OP_TABLE_WRITE, 5'd0, 16'h8000, 1'b1));
        pending_items.push_back(make_item(OP_TABLE_WRITE, 5'd25, 16'h7FFF, 1'b0));
        pending_items.push_back(make_item(OP_TABLE_WRITE, 5'd5, -16'sd7, 1'b0));
        pending_items.push_back(make_item(OP_TABLE_WRITE, 5'd30, 16'h1234, 1'b1));
        for (int i = 0; i < 22; i++)
            pending_items.push_back(make_item(OP_RESIDUE, pattern[i % 6],
                                              (i % 2) ? 16'h8000 : 16'h7FFF, i == 0));
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                wait_drained();
                if (ph < 6) begin
                    write_reg(CFG_CORE_LENGTH, CFG_DATA_W'(CORE_PLAN[ph]));
                    write_reg(CFG_WEDGE_LENGTH, CFG_DATA_W'(WEDGE_PLAN[ph]));
                end else begin
                    write_reg(CFG_CORE_LENGTH, CFG_DATA_W'($urandom));
                    write_reg(CFG_WEDGE_LENGTH, CFG_DATA_W'($urandom));
                end
            end else begin
                for (int l = 0; l < TABLE_SIZE; l++)
                    pending_items.push_back(make_item(OP_TABLE_WRITE, LETTER_W'(l),
                                                      16'($urandom), 1'b0));
            end
            send_idle_max = (ph % 3 == 1) ? 0 : IDLE_MAX;
            recv_idle_max = (ph % 3 == 2) ? 0 : IDLE_MAX;
            queue_sequences(PHASE_ITEMS);
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
